FILE: rtl/cma_pkg.sv
// shared types and constants of the centered moving average block
`default_nettype none
package cma_pkg;

  localparam int XY_W   = 32;
  localparam int DATA_W = 32;
  localparam int APB_AW = 3;
  localparam int WIN_W  = 6;
  localparam int SEEN_W = 7;

  localparam logic [APB_AW-1:0] ADDR_WINDOW = 3'h0;
  localparam logic [WIN_W-1:0]  WIN_RESET   = 6'd3;
  localparam logic [SEEN_W-1:0] SEEN_MAX    = 7'd127;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } cma_state_t;

endpackage
`default_nettype wire

FILE: rtl/cma_if.sv
// stream channels for input points and averaged results
`default_nettype none
interface cma_point_if;
  import cma_pkg::*;
  logic              valid;
  logic              ready;
  logic signed [XY_W-1:0] x_value;
  logic signed [XY_W-1:0] y_value;
  logic              last_point;
  modport source(output valid, x_value, y_value, last_point, input ready);
  modport sink(input valid, x_value, y_value, last_point, output ready);
endinterface

interface cma_result_if;
  import cma_pkg::*;
  logic              valid;
  logic              ready;
  logic signed [XY_W-1:0] x_out;
  logic signed [XY_W-1:0] mean_y;
  logic              last_result;
  logic              status;
  modport source(output valid, x_out, mean_y, last_result, status, input ready);
  modport sink(input valid, x_out, mean_y, last_result, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/centered_moving_average.sv
// centered moving average filter: top level with history memories and sequencer
//
// Points arrive one per transfer and are held in two ring memories; the block
// is ready only while idle. After a point is taken, every result that is now
// complete is produced one after another: the y samples of its clipped window
// are summed through the memory read port at one sample a cycle, then the sum
// goes through a shared bit-serial divider that works through the sum one bit
// at a time. The clipped window length of a result is at most 2*radius+1; a
// point that completes no result only passes the check state before the block
// is ready again. A last point flushes all pending results. The window
// register sits at byte address 0 and must only be written while the block is
// idle. The memories need no clearing after reset, so points are taken
// straight away.
`default_nettype none
module centered_moving_average #(
  parameter int MAX_WINDOW   = 63,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  cma_point_if.sink                     points,
  cma_result_if.source                  results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cma_pkg::APB_AW-1:0]    paddr,
  input  logic [cma_pkg::DATA_W-1:0]    pwdata,
  output logic [cma_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import cma_pkg::*;

  localparam int RAD_MAX = MAX_WINDOW / 2;
  localparam int RW      = $clog2(RAD_MAX + 1);
  localparam int PW      = $clog2(RAD_MAX + 2);
  localparam int CW      = $clog2(2 * RAD_MAX + 2);
  localparam int YA      = $clog2(2 * RAD_MAX + 1);
  localparam int YD      = 1 << YA;
  localparam int XA      = $clog2(RAD_MAX + 1);
  localparam int XD      = 1 << XA;
  localparam int SUM_W   = SAMPLE_WIDTH + CW;
  localparam int YEXT_W  = (SAMPLE_WIDTH > XY_W) ? SAMPLE_WIDTH : XY_W;
  localparam int OW      = (SAMPLE_WIDTH < XY_W) ? SAMPLE_WIDTH : XY_W;
  localparam int WC_W    = (WIN_W > $clog2(MAX_WINDOW + 1)) ? WIN_W : $clog2(MAX_WINDOW + 1);

  cma_state_t state;
  cma_state_t state_next;

  logic [WIN_W-1:0] window;
  logic [WC_W-1:0]  win_clamped;
  logic [RW-1:0]    radius;

  // history rings
  logic [SAMPLE_WIDTH-1:0] y_mem [YD];
  logic [XY_W-1:0]         x_mem [XD];
  logic [SAMPLE_WIDTH-1:0] y_rd;
  logic [XY_W-1:0]         x_rd;
  logic [YEXT_W-1:0]       y_wide;

  logic [YA-1:0]     wp;
  logic [SEEN_W-1:0] seen;
  logic [PW-1:0]     pending;
  logic              last_flag;
  logic [XY_W-1:0]   x_in;

  logic [YA-1:0]    rd_addr;
  logic [XA-1:0]    x_addr;
  logic [CW-1:0]    issue_left;
  logic             rd_pend;
  logic [CW-1:0]    count;
  logic signed [SUM_W-1:0] sum;
  logic             res_last;

  logic [PW-1:0]     back;
  logic [SEEN_W-1:0] left_raw;
  logic [RW-1:0]     left;
  logic [PW-1:0]     right;
  logic [CW-1:0]     count_next;
  logic [YA-1:0]     kpos;

  logic                    single;
  logic                    more;
  logic                    div_start;
  logic                    div_done;
  logic signed [SUM_W-1:0] quot;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_WINDOW) ? DATA_W'(window) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WIN_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_WINDOW)) begin
      window <= pwdata[WIN_W-1:0];
    end
  end

  always_comb begin
    win_clamped = WC_W'(window);
    if (win_clamped < WC_W'(2)) begin
      win_clamped = WC_W'(2);
    end else if (win_clamped > WC_W'(MAX_WINDOW)) begin
      win_clamped = WC_W'(MAX_WINDOW);
    end
    radius = RW'(win_clamped >> 1);
  end

  // window geometry of the next result
  always_comb begin
    back       = pending - 1'b1;
    kpos       = wp - 1'b1 - YA'(back);
    left_raw   = seen - 1'b1 - SEEN_W'(back);
    left       = (left_raw > SEEN_W'(radius)) ? radius : RW'(left_raw);
    right      = (back > PW'(radius)) ? PW'(radius) : back;
    count_next = CW'(left) + CW'(right) + 1'b1;
  end

  assign single = last_flag && (seen == SEEN_W'(1));
  assign more   = (pending != '0) && (last_flag || (pending > PW'(radius)));
  assign y_wide = YEXT_W'($unsigned(points.y_value));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    points.ready  = 1'b0;
    results.valid = 1'b0;
    div_start     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        points.ready = 1'b1;
        if (points.valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (single) begin
          state_next = ST_OUT;
        end else if (more) begin
          state_next = ST_SETUP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SETUP: state_next = ST_ACC;
      ST_ACC: begin
        if (issue_left == '0 && !rd_pend) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        results.valid = 1'b1;
        if (results.ready) begin
          state_next = (!single && more) ? ST_SETUP : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // series control
  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      seen       <= '0;
      pending    <= '0;
      issue_left <= '0;
      rd_pend    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (points.valid) begin
            wp      <= wp + 1'b1;
            seen    <= (seen == SEEN_MAX) ? seen : seen + 1'b1;
            pending <= pending + 1'b1;
          end
        end
        ST_SETUP: begin
          pending    <= back;
          issue_left <= count_next;
          rd_pend    <= 1'b0;
        end
        ST_ACC: begin
          if (issue_left != '0) begin
            issue_left <= issue_left - 1'b1;
          end
          rd_pend <= issue_left != '0;
        end
        ST_OUT: begin
          if (results.ready && last_flag && (single || pending == '0)) begin
            wp      <= '0;
            seen    <= '0;
            pending <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (points.valid) begin
          last_flag <= points.last_point;
          x_in      <= points.x_value;
        end
      end
      ST_SETUP: begin
        x_addr   <= kpos[XA-1:0];
        rd_addr  <= kpos - YA'(left);
        count    <= count_next;
        sum      <= '0;
        res_last <= last_flag && (back == '0);
      end
      ST_ACC: begin
        if (issue_left != '0) begin
          rd_addr <= rd_addr + 1'b1;
        end
        if (rd_pend) begin
          sum <= sum + SUM_W'($signed(y_rd));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && points.valid) begin
      y_mem[wp]          <= y_wide[SAMPLE_WIDTH-1:0];
      x_mem[wp[XA-1:0]]  <= points.x_value;
    end
    y_rd <= y_mem[rd_addr];
    x_rd <= x_mem[x_addr];
  end

  cma_div #(
    .DVD_W(SUM_W),
    .DVS_W(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (quot)
  );

  assign results.x_out       = single ? x_in : x_rd;
  assign results.mean_y      = single ? '0 : XY_W'(quot[OW-1:0]);
  assign results.last_result = single ? 1'b1 : res_last;
  assign results.status      = single ? STATUS_SHORT : STATUS_OK;

endmodule
`default_nettype wire

FILE: rtl/cma_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none
module cma_div #(
  parameter int DVD_W = 38,
  parameter int DVS_W = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic        [DVS_W-1:0] divisor,
  output logic                    done,
  output logic signed [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  mag;
  logic [DVD_W-1:0]  mag_next;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  rem_next;
  logic [DVS_W-1:0]  dvs;
  logic              neg;
  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DVS_W:0]    trial;
  logic              fits;

  always_comb begin
    trial    = {rem, mag[DVD_W-1]};
    fits     = trial >= {1'b0, dvs};
    rem_next = fits ? DVS_W'(trial - {1'b0, dvs}) : DVS_W'(trial);
    mag_next = {mag[DVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DVD_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
      neg <= dividend[DVD_W-1];
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      mag <= mag_next;
      rem <= rem_next;
    end
  end

  assign quotient = neg ? -$signed(mag) : $signed(mag);

endmodule
`default_nettype wire
